// ----- hw/rtl/edc_pkg.sv -----
// shared widths, lane codes and pipeline stage types for the disc collision block
// no dependencies

package edc_pkg;

    localparam int LANES      = 4;
    localparam int VEL_W      = 32;
    localparam int DEN_W      = 83;
    localparam int DEN2_W     = DEN_W + 1;
    localparam int NUM_W      = 119;
    localparam int Q_W        = 35;
    localparam int PRE_STAGES = 8;
    localparam int PIPE_DEPTH = PRE_STAGES + Q_W;

    localparam int LANE_1X = 0;
    localparam int LANE_1Y = 1;
    localparam int LANE_2X = 2;
    localparam int LANE_2Y = 3;

    typedef struct packed {
        logic [LANES-1:0][VEL_W-1:0] vel;
        logic [15:0]                 m1;
        logic [15:0]                 m2;
        logic                        coin;
        logic                        pass;
    } ctl_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] rem;
        logic [LANES-1:0][Q_W-1:0]   quo;
        logic [DEN2_W-1:0]           den2;
        logic [LANES-1:0][VEL_W-1:0] vel;
        logic                        sgx;
        logic                        sgy;
        logic                        coin;
        logic                        pass;
    } div_t;

    typedef struct packed {
        logic [LANES-1:0][VEL_W-1:0] vel;
        logic                        coin;
        logic                        sat;
    } res_t;

endpackage

// ----- hw/rtl/elastic_disc_collision.sv -----
// elastic collision of two discs, pipelined datapath with output skid buffer
// depends on edc_pkg
//
// input channel s_*: masses, centre positions and velocities of two discs,
// one transaction per pair; output channel m_*: both velocities after the
// collision plus coincide and saturation flags, one transaction per input.
// positions and velocities are signed fixed point in 32 bits; the update is
// a ratio of equal scale, so the fraction count does not change the logic.
// the datapath has 8 arithmetic stages (differences, 33x33 products, sums,
// abs and mass product, split products, recombined products, mass products,
// dividend), 35 restoring divider stages producing one quotient bit each,
// then the rounding add and clamp into the output register.
// throughput is one transaction per cycle while s_ready is high; the pipeline
// advances as a whole and a two-entry output buffer keeps s_ready registered,
// so one result may wait at the output while the pipeline keeps taking input.
// when the receiver stalls, the second entry fills and s_ready drops until
// the buffered result moves up; nothing is lost or repeated.
// synchronous active-low reset empties the pipeline and the output buffer.

module elastic_disc_collision
    import edc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_first_mass,
    input  logic [15:0] s_second_mass,
    input  logic [31:0] s_first_x,
    input  logic [31:0] s_first_y,
    input  logic [31:0] s_second_x,
    input  logic [31:0] s_second_y,
    input  logic [31:0] s_first_vx,
    input  logic [31:0] s_first_vy,
    input  logic [31:0] s_second_vx,
    input  logic [31:0] s_second_vy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_first_vx_new,
    output logic [31:0] m_first_vy_new,
    output logic [31:0] m_second_vx_new,
    output logic [31:0] m_second_vy_new,
    output logic        m_centres_coincide,
    output logic        m_saturated
);

    logic                  en;
    logic                  arrive;
    logic [PIPE_DEPTH-1:0] pv_reg;

    // stage 1
    logic signed [32:0] s1_dx_reg, s1_dy_reg, s1_dvx_reg, s1_dvy_reg;
    logic [16:0]        s1_msum_reg;
    ctl_t               s1_c_reg;
    // stage 2
    logic signed [65:0] s2_pxx_reg, s2_pyy_reg, s2_dxx_reg, s2_dyy_reg;
    logic [32:0]        s2_ax_reg, s2_ay_reg;
    logic               s2_sx_reg, s2_sy_reg;
    logic [16:0]        s2_msum_reg;
    ctl_t               s2_c_reg;
    // stage 3
    logic signed [66:0] s3_w_reg;
    logic [65:0]        s3_dd_reg;
    logic [32:0]        s3_ax_reg, s3_ay_reg;
    logic               s3_sx_reg, s3_sy_reg;
    logic [16:0]        s3_msum_reg;
    ctl_t               s3_c_reg;
    // stage 4
    logic [65:0]        s4_aw_reg;
    logic [49:0]        s4_denl_reg, s4_denh_reg;
    logic [32:0]        s4_ax_reg, s4_ay_reg;
    logic               s4_sgx_reg, s4_sgy_reg;
    ctl_t               s4_c_reg;
    // stage 5
    logic [65:0]        s5_pxl_reg, s5_pxh_reg, s5_pyl_reg, s5_pyh_reg;
    logic [DEN_W-1:0]   s5_den_reg;
    logic               s5_sgx_reg, s5_sgy_reg;
    ctl_t               s5_c_reg;
    // stage 6
    logic [98:0]        s6_px_reg, s6_py_reg;
    logic [DEN_W-1:0]   s6_den_reg;
    logic               s6_sgx_reg, s6_sgy_reg;
    ctl_t               s6_c_reg;
    // stage 7
    logic [LANES-1:0][65:0] s7_lo_reg, s7_hi_reg;
    logic [DEN_W-1:0]       s7_den_reg;
    logic                   s7_sgx_reg, s7_sgy_reg;
    ctl_t                   s7_c_reg;
    // stage 8 and divider
    div_t stg_reg  [Q_W+1];
    div_t stg_next [Q_W+1];

    res_t res_next;
    res_t out_reg, spr_reg;
    logic out_vld_reg, spr_vld_reg;

    assign en      = !spr_vld_reg;
    assign s_ready = en;
    assign arrive  = en && pv_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (en) begin
            pv_reg <= {pv_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_dx_reg   <= {s_second_x[31], s_second_x} - {s_first_x[31], s_first_x};
            s1_dy_reg   <= {s_second_y[31], s_second_y} - {s_first_y[31], s_first_y};
            s1_dvx_reg  <= {s_first_vx[31], s_first_vx} - {s_second_vx[31], s_second_vx};
            s1_dvy_reg  <= {s_first_vy[31], s_first_vy} - {s_second_vy[31], s_second_vy};
            s1_msum_reg <= {1'b0, s_first_mass} + {1'b0, s_second_mass};
            s1_c_reg.vel[LANE_1X] <= s_first_vx;
            s1_c_reg.vel[LANE_1Y] <= s_first_vy;
            s1_c_reg.vel[LANE_2X] <= s_second_vx;
            s1_c_reg.vel[LANE_2Y] <= s_second_vy;
            s1_c_reg.m1   <= s_first_mass;
            s1_c_reg.m2   <= s_second_mass;
            s1_c_reg.coin <= (s_first_x == s_second_x) && (s_first_y == s_second_y);
            s1_c_reg.pass <= ((s_first_x == s_second_x) && (s_first_y == s_second_y))
                             || ((s_first_mass == 16'd0) && (s_second_mass == 16'd0));

            s2_pxx_reg  <= 66'(s1_dvx_reg) * 66'(s1_dx_reg);
            s2_pyy_reg  <= 66'(s1_dvy_reg) * 66'(s1_dy_reg);
            s2_dxx_reg  <= 66'(s1_dx_reg) * 66'(s1_dx_reg);
            s2_dyy_reg  <= 66'(s1_dy_reg) * 66'(s1_dy_reg);
            s2_ax_reg   <= s1_dx_reg[32] ? 33'(-s1_dx_reg) : 33'(s1_dx_reg);
            s2_ay_reg   <= s1_dy_reg[32] ? 33'(-s1_dy_reg) : 33'(s1_dy_reg);
            s2_sx_reg   <= s1_dx_reg[32];
            s2_sy_reg   <= s1_dy_reg[32];
            s2_msum_reg <= s1_msum_reg;
            s2_c_reg    <= s1_c_reg;

            s3_w_reg    <= 67'(s2_pxx_reg) + 67'(s2_pyy_reg);
            s3_dd_reg   <= {1'b0, s2_dxx_reg[64:0]} + {1'b0, s2_dyy_reg[64:0]};
            s3_ax_reg   <= s2_ax_reg;
            s3_ay_reg   <= s2_ay_reg;
            s3_sx_reg   <= s2_sx_reg;
            s3_sy_reg   <= s2_sy_reg;
            s3_msum_reg <= s2_msum_reg;
            s3_c_reg    <= s2_c_reg;

            s4_aw_reg   <= s3_w_reg[66] ? 66'(-s3_w_reg) : 66'(s3_w_reg);
            s4_denl_reg <= 50'(s3_msum_reg) * 50'(s3_dd_reg[32:0]);
            s4_denh_reg <= 50'(s3_msum_reg) * 50'(s3_dd_reg[65:33]);
            s4_ax_reg   <= s3_ax_reg;
            s4_ay_reg   <= s3_ay_reg;
            s4_sgx_reg  <= s3_w_reg[66] ^ s3_sx_reg;
            s4_sgy_reg  <= s3_w_reg[66] ^ s3_sy_reg;
            s4_c_reg    <= s3_c_reg;

            s5_pxl_reg  <= 66'(s4_aw_reg[32:0]) * 66'(s4_ax_reg);
            s5_pxh_reg  <= 66'(s4_aw_reg[65:33]) * 66'(s4_ax_reg);
            s5_pyl_reg  <= 66'(s4_aw_reg[32:0]) * 66'(s4_ay_reg);
            s5_pyh_reg  <= 66'(s4_aw_reg[65:33]) * 66'(s4_ay_reg);
            s5_den_reg  <= (DEN_W'(s4_denh_reg) << 33) + DEN_W'(s4_denl_reg);
            s5_sgx_reg  <= s4_sgx_reg;
            s5_sgy_reg  <= s4_sgy_reg;
            s5_c_reg    <= s4_c_reg;

            s6_px_reg   <= (99'(s5_pxh_reg) << 33) + 99'(s5_pxl_reg);
            s6_py_reg   <= (99'(s5_pyh_reg) << 33) + 99'(s5_pyl_reg);
            s6_den_reg  <= s5_den_reg;
            s6_sgx_reg  <= s5_sgx_reg;
            s6_sgy_reg  <= s5_sgy_reg;
            s6_c_reg    <= s5_c_reg;

            s7_lo_reg[LANE_1X] <= 66'(s6_px_reg[49:0]) * 66'(s6_c_reg.m2);
            s7_hi_reg[LANE_1X] <= 66'(s6_px_reg[98:50]) * 66'(s6_c_reg.m2);
            s7_lo_reg[LANE_1Y] <= 66'(s6_py_reg[49:0]) * 66'(s6_c_reg.m2);
            s7_hi_reg[LANE_1Y] <= 66'(s6_py_reg[98:50]) * 66'(s6_c_reg.m2);
            s7_lo_reg[LANE_2X] <= 66'(s6_px_reg[49:0]) * 66'(s6_c_reg.m1);
            s7_hi_reg[LANE_2X] <= 66'(s6_px_reg[98:50]) * 66'(s6_c_reg.m1);
            s7_lo_reg[LANE_2Y] <= 66'(s6_py_reg[49:0]) * 66'(s6_c_reg.m1);
            s7_hi_reg[LANE_2Y] <= 66'(s6_py_reg[98:50]) * 66'(s6_c_reg.m1);
            s7_den_reg <= s6_den_reg;
            s7_sgx_reg <= s6_sgx_reg;
            s7_sgy_reg <= s6_sgy_reg;
            s7_c_reg   <= s6_c_reg;

            for (int k = 0; k <= Q_W; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // dividend 2*|num| + den against divisor 2*den, one quotient bit per stage
    always_comb begin
        logic [NUM_W-1:0] dvs;
        dvs = '0;
        stg_next[0].den2 = {s7_den_reg, 1'b0};
        stg_next[0].vel  = s7_c_reg.vel;
        stg_next[0].sgx  = s7_sgx_reg;
        stg_next[0].sgy  = s7_sgy_reg;
        stg_next[0].coin = s7_c_reg.coin;
        stg_next[0].pass = s7_c_reg.pass;
        stg_next[0].quo  = '0;
        for (int l = 0; l < LANES; l++) begin
            stg_next[0].rem[l] = (NUM_W'(s7_hi_reg[l]) << 52)
                               + (NUM_W'(s7_lo_reg[l]) << 2)
                               + NUM_W'(s7_den_reg);
        end
        for (int k = 1; k <= Q_W; k++) begin
            stg_next[k] = stg_reg[k-1];
            dvs = NUM_W'(stg_reg[k-1].den2) << (Q_W - k);
            for (int l = 0; l < LANES; l++) begin
                if (stg_reg[k-1].rem[l] >= dvs) begin
                    stg_next[k].rem[l]         = stg_reg[k-1].rem[l] - dvs;
                    stg_next[k].quo[l][Q_W-k]  = 1'b1;
                end
            end
        end
    end

    // rounding add and clamp
    always_comb begin
        logic        sg;
        logic        up;
        logic [36:0] r;
        res_next.coin = stg_reg[Q_W].coin;
        res_next.sat  = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            sg = (l == LANE_1Y || l == LANE_2Y) ? stg_reg[Q_W].sgy : stg_reg[Q_W].sgx;
            up = (l == LANE_1X || l == LANE_1Y) ? sg : !sg;
            r  = up ? {{5{stg_reg[Q_W].vel[l][31]}}, stg_reg[Q_W].vel[l]}
                      + {2'b00, stg_reg[Q_W].quo[l]}
                    : {{5{stg_reg[Q_W].vel[l][31]}}, stg_reg[Q_W].vel[l]}
                      - {2'b00, stg_reg[Q_W].quo[l]};
            if (stg_reg[Q_W].pass) begin
                res_next.vel[l] = stg_reg[Q_W].vel[l];
            end else if ((r[36:31] != 6'b000000) && (r[36:31] != 6'b111111)) begin
                res_next.sat    = 1'b1;
                res_next.vel[l] = r[36] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                res_next.vel[l] = r[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            spr_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            if (spr_vld_reg) begin
                out_vld_reg <= 1'b1;
                spr_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= arrive;
            end
        end else if (arrive) begin
            spr_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_ready) begin
            out_reg <= spr_vld_reg ? spr_reg : res_next;
        end else if (arrive) begin
            spr_reg <= res_next;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_first_vx_new     = out_reg.vel[LANE_1X];
    assign m_first_vy_new     = out_reg.vel[LANE_1Y];
    assign m_second_vx_new    = out_reg.vel[LANE_2X];
    assign m_second_vy_new    = out_reg.vel[LANE_2Y];
    assign m_centres_coincide = out_reg.coin;
    assign m_saturated        = out_reg.sat;

`ifndef SYNTHESIS
    a_spare_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        spr_vld_reg |-> out_vld_reg)
        else $error("spare entry holds a transaction while output is empty");

    a_spare_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_ready && arrive |=> spr_vld_reg && !s_ready)
        else $error("stalled arrival not parked in spare entry");

    a_coincide_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_centres_coincide |-> !m_saturated)
        else $error("coinciding centres flagged as saturated");
`endif

endmodule

// ----- test/elastic_disc_collision_tb.sv -----
// testbench for elastic_disc_collision: directed, random and drain-pause tests
// depends on edc_pkg and the elastic_disc_collision rtl; self-checking, no files
`timescale 1ns / 100ps

module elastic_disc_collision_tb
    import edc_pkg::*;
();

    typedef struct {
        logic [15:0]        m1;
        logic [15:0]        m2;
        logic signed [31:0] x1, y1, x2, y2;
        logic signed [31:0] v1x, v1y, v2x, v2y;
    } pair_t;

    typedef struct {
        logic [LANES-1:0][VEL_W-1:0] vel;
        logic                        coin;
        logic                        sat;
    } bounce_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_first_mass = '0;
    logic [15:0] s_second_mass = '0;
    logic [31:0] s_first_x = '0;
    logic [31:0] s_first_y = '0;
    logic [31:0] s_second_x = '0;
    logic [31:0] s_second_y = '0;
    logic [31:0] s_first_vx = '0;
    logic [31:0] s_first_vy = '0;
    logic [31:0] s_second_vx = '0;
    logic [31:0] s_second_vy = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_first_vx_new;
    logic [31:0] m_first_vy_new;
    logic [31:0] m_second_vx_new;
    logic [31:0] m_second_vy_new;
    logic        m_centres_coincide;
    logic        m_saturated;

    bounce_t pending_bounces[$];
    int      mismatch_count = 0;
    int      stall_mode = 0;
    int      stall_cycles = 0;

    always #4 aclk = ~aclk;

    elastic_disc_collision u_dut (.*);

    function automatic logic signed [63:0] nudge_velocity(input logic signed [31:0] v,
            input logic signed [255:0] num, input logic signed [255:0] den);
        logic signed [255:0] mag;
        logic signed [255:0] step;
        mag  = (num < 0) ? -num : num;
        step = (2 * mag + den) / (2 * den);
        if (step > (256'sd1 <<< 40))
            step = 256'sd1 <<< 40;
        return (num < 0) ? 64'(v) - 64'(step) : 64'(v) + 64'(step);
    endfunction

    function automatic logic [31:0] clamp_velocity(input logic signed [63:0] v,
            inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic bounce_t predict_bounce(input pair_t p);
        logic signed [255:0] dx, dy, w, dd, den, k1, k2, msum;
        logic signed [63:0]  r[LANES];
        bounce_t             b;
        logic                sat;
        dx = 256'(p.x2) - 256'(p.x1);
        dy = 256'(p.y2) - 256'(p.y1);
        r[LANE_1X] = p.v1x;
        r[LANE_1Y] = p.v1y;
        r[LANE_2X] = p.v2x;
        r[LANE_2Y] = p.v2y;
        b.coin = (dx == 0) && (dy == 0);
        msum = $signed({240'd0, p.m1}) + $signed({240'd0, p.m2});
        if (!b.coin && msum != 0) begin
            w   = (256'(p.v1x) - 256'(p.v2x)) * dx + (256'(p.v1y) - 256'(p.v2y)) * dy;
            dd  = dx * dx + dy * dy;
            den = msum * dd;
            k1  = -(2 * $signed({240'd0, p.m2}) * w);
            k2  = 2 * $signed({240'd0, p.m1}) * w;
            r[LANE_1X] = nudge_velocity(p.v1x, k1 * dx, den);
            r[LANE_1Y] = nudge_velocity(p.v1y, k1 * dy, den);
            r[LANE_2X] = nudge_velocity(p.v2x, k2 * dx, den);
            r[LANE_2Y] = nudge_velocity(p.v2y, k2 * dy, den);
        end
        sat = 1'b0;
        for (int i = 0; i < LANES; i++)
            b.vel[i] = clamp_velocity(r[i], sat);
        b.sat = sat;
        return b;
    endfunction

    task automatic send_pair(input pair_t p);
        s_valid       <= 1'b1;
        s_first_mass  <= p.m1;
        s_second_mass <= p.m2;
        s_first_x     <= p.x1;
        s_first_y     <= p.y1;
        s_second_x    <= p.x2;
        s_second_y    <= p.y2;
        s_first_vx    <= p.v1x;
        s_first_vy    <= p.v1y;
        s_second_vx   <= p.v2x;
        s_second_vy   <= p.v2y;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_bounces.push_back(predict_bounce(p));
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        unique case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000);
            2: return 32'($signed($urandom_range(0, 32'h3ff)) - 32'sh200);
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            4: return '0;
            default: return 32'($signed($urandom_range(0, 32'h1ff_ffff)) - 32'sh100_0000);
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        p.m1  = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, 50));
        p.m2  = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, 50));
        p.x1  = pick_value();
        p.y1  = pick_value();
        p.x2  = $urandom_range(0, 9) == 0 ? p.x1 : pick_value();
        p.y2  = $urandom_range(0, 9) == 0 ? p.y1 : pick_value();
        p.v1x = pick_value();
        p.v1y = pick_value();
        p.v2x = pick_value();
        p.v2y = pick_value();
        return p;
    endfunction

    function automatic pair_t make_pair(input logic [15:0] m1, m2,
            input logic [31:0] x1, y1, x2, y2, v1x, v1y, v2x, v2y);
        pair_t p;
        p.m1 = m1;   p.m2 = m2;
        p.x1 = x1;   p.y1 = y1;   p.x2 = x2;   p.y2 = y2;
        p.v1x = v1x; p.v1y = v1y; p.v2x = v2x; p.v2y = v2y;
        return p;
    endfunction

    task automatic test_directed();
        // head-on equal masses, first disc at rest in x, glancing and coincident centres
        send_pair(make_pair(1, 1, 0, 0, 32'h1_0000, 0, 32'h1_0000, 0, 0, 0));
        send_pair(make_pair(3, 5, 0, 0, 32'h2_0000, 32'h1_0000, 0, 32'h8000,
                            32'hffff_0000, 0));
        send_pair(make_pair(2, 7, 32'h1234, 32'h5678, 32'h1234, 32'h5678,
                            32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000));
        send_pair(make_pair(65535, 65535, 32'h7fff_ffff, 32'h8000_0000,
                            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                            32'h8000_0000, 32'h7fff_ffff));
        send_pair(make_pair(1, 65535, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000));
        send_pair(make_pair(65535, 1, 32'h8000_0000, 0, 32'h7fff_ffff, 0,
                            32'h7fff_ffff, 0, 32'h8000_0000, 0));
        send_pair(make_pair(65535, 1, 0, 32'h8000_0000, 0, 32'h7fff_ffff,
                            0, 32'h8000_0000, 0, 32'h7fff_ffff));
        send_pair(make_pair(1, 1, 0, 0, 1, 1, 32'hffff_ffff, 32'hffff_ffff, 1, 1));
        send_pair(make_pair(10, 1, 0, 0, 32'h3_0000, 32'h4_0000, 32'h5_0000, 0, 0, 0));
        send_pair(make_pair(1, 10, 0, 0, 1, 0, 32'h7fff_ffff, 0, 32'h8000_0000, 0));
        send_pair(make_pair(4, 4, 32'hffff_ffff, 0, 0, 32'hffff_ffff,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
        send_pair(make_pair(16'hffff, 16'h8001, 32'h5555_5555, 32'haaaa_aaaa,
                            32'haaaa_aaaa, 32'h5555_5555, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
                            32'h3333_3333, 32'hcccc_cccc));
        idle_sender(1);
    endtask

    task automatic test_random(input int items);
        int sent;
        int burst;
        sent = 0;
        while (sent < items) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < items; i++) begin
                send_pair(random_pair());
                sent++;
            end
            idle_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
    endtask

    task automatic test_drain_pause();
        test_random(20);
        idle_sender(1);
        while (pending_bounces.size() != 0)
            @(posedge aclk);
        test_random(20);
    endtask

    always @(posedge aclk) begin
        bounce_t want;
        if (m_valid && m_ready) begin
            if (pending_bounces.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction at %0t", $realtime);
            end else begin
                want = pending_bounces.pop_front();
                if (want.vel[LANE_1X] !== m_first_vx_new || want.vel[LANE_1Y] !== m_first_vy_new ||
                        want.vel[LANE_2X] !== m_second_vx_new ||
                        want.vel[LANE_2Y] !== m_second_vy_new ||
                        want.coin !== m_centres_coincide || want.sat !== m_saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at %0t exp %h %h %h %h c%b s%b got %h %h %h %h c%b s%b",
                                 $realtime, want.vel[LANE_1X], want.vel[LANE_1Y],
                                 want.vel[LANE_2X], want.vel[LANE_2Y], want.coin, want.sat,
                                 m_first_vx_new, m_first_vy_new, m_second_vx_new,
                                 m_second_vy_new, m_centres_coincide, m_saturated);
                end
            end
        end
        // receiver stall pattern is re-picked whenever its hold counter runs out
        if (stall_cycles == 0) begin
            stall_mode   <= $urandom_range(0, 2);
            stall_cycles <= $urandom_range(50, 250);
        end else begin
            stall_cycles <= stall_cycles - 1;
        end
        unique case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(250);
        test_drain_pause();
        test_random(260);
        idle_sender(1);
        while (pending_bounces.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && pending_bounces.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
